>>> sv/mtu_pkg.sv
`default_nettype none
package mtu_pkg;

  // Word format: signed fixed point, FRAC_W fractional bits
  localparam int WORD_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int GROUPS      = 4;
  localparam int GROUP_CELLS = 4;
  localparam int GRP_W       = $clog2(GROUPS);
  localparam int REQ_W       = 3;

  // Exact product, product after the fractional shift, and a sum of four of those
  localparam int PROD_W  = 2 * WORD_W;
  localparam int TRUNC_W = PROD_W - FRAC_W;
  localparam int ACC_W   = TRUNC_W + 2;

  localparam logic [GRP_W-1:0] LAST_GROUP = GRP_W'(GROUPS - 1);

  typedef logic signed [WORD_W-1:0]  word_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [TRUNC_W-1:0] trunc_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  // One group of four cells, and the whole matrix as four groups
  typedef word_t  [GROUP_CELLS-1:0] group_t;
  typedef group_t [GROUPS-1:0]      matrix_t;

  localparam word_t ONE_FIX  = word_t'(WORD_W'(1) << FRAC_W);
  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 3'd0,
    REQ_READ   = 3'd1,
    REQ_MUL    = 3'd2,
    REQ_ADD    = 3'd3,
    REQ_SUB    = 3'd4,
    REQ_SCALE  = 3'd5,
    REQ_ROTATE = 3'd6
  } req_e;

  // Request held in the input register
  typedef struct packed {
    req_e             req;
    logic [GRP_W-1:0] grp;
    group_t           vals;
    logic             commit;
  } item_t;

  // Update command from the datapath to the matrix store
  typedef struct packed {
    logic             en;
    req_e             req;
    logic [GRP_W-1:0] grp;
    logic             commit;
    group_t           load_vals;
    group_t           mul_res;
  } upd_t;

  // Clamp a wide signed sum to one word
  function automatic word_t sat_word(input acc_t a);
    logic [ACC_W-WORD_W:0] top_bits;
    word_t                 r;
    top_bits = a[ACC_W-1:WORD_W-1];
    if (top_bits == '0 || top_bits == '1) begin
      r = a[WORD_W-1:0];
    end else if (a[ACC_W-1]) begin
      r = WORD_MIN;
    end else begin
      r = WORD_MAX;
    end
    return r;
  endfunction

  function automatic matrix_t ident_matrix();
    matrix_t m;
    for (int g = 0; g < GROUPS; g++) begin
      for (int c = 0; c < GROUP_CELLS; c++) begin
        m[g][c] = (g == c) ? ONE_FIX : '0;
      end
    end
    return m;
  endfunction

  function automatic logic is_identity(input matrix_t m);
    matrix_t ref_m;
    ref_m = ident_matrix();
    return (m == ref_m);
  endfunction

endpackage
`default_nettype wire

>>> sv/mtu_ifs.sv
`default_nettype none
// Request channel
interface mtu_req_if;
  logic                            valid;
  logic                            ready;
  logic [mtu_pkg::REQ_W-1:0]       req_type;
  logic [mtu_pkg::GRP_W-1:0]       group;
  logic signed [mtu_pkg::WORD_W-1:0] val0;
  logic signed [mtu_pkg::WORD_W-1:0] val1;
  logic signed [mtu_pkg::WORD_W-1:0] val2;
  logic signed [mtu_pkg::WORD_W-1:0] val3;
  logic                            commit;

  modport source (output valid, req_type, group, val0, val1, val2, val3, commit,
                  input ready);
  modport sink   (input valid, req_type, group, val0, val1, val2, val3, commit,
                  output ready);
endinterface

// Result channel
interface mtu_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [mtu_pkg::WORD_W-1:0] res0;
  logic signed [mtu_pkg::WORD_W-1:0] res1;
  logic signed [mtu_pkg::WORD_W-1:0] res2;
  logic signed [mtu_pkg::WORD_W-1:0] res3;
  logic                              is_ident;

  modport source (output valid, res0, res1, res2, res3, is_ident, input ready);
  modport sink   (input valid, res0, res1, res2, res3, is_ident, output ready);
endinterface
`default_nettype wire

>>> sv/mtu_lane.sv
`default_nettype none
// One result lane: column dot product, add/subtract, scale, rotate, load and read
module mtu_lane (
  input  wire mtu_pkg::req_e   req_i,
  input  wire mtu_pkg::group_t col_i,       // M[4k+i], k = 0..3
  input  wire mtu_pkg::group_t dot_op_i,    // operand group for the dot product
  input  wire mtu_pkg::word_t  cell_i,      // M[4g+i]
  input  wire mtu_pkg::word_t  own_i,       // operand element i
  input  wire logic            rot_zero_i,  // lane gives zero on rotate
  output mtu_pkg::word_t       res_o
);

  mtu_pkg::word_t  mul_a [mtu_pkg::GROUP_CELLS];
  mtu_pkg::word_t  mul_b [mtu_pkg::GROUP_CELLS];
  mtu_pkg::prod_t  prod  [mtu_pkg::GROUP_CELLS];
  mtu_pkg::trunc_t trunc [mtu_pkg::GROUP_CELLS];
  mtu_pkg::acc_t   dot_sum;
  mtu_pkg::acc_t   as_sum;
  mtu_pkg::word_t  dot_sat;

  // Form the four products; scale borrows the first multiplier
  always_comb begin
    for (int k = 0; k < mtu_pkg::GROUP_CELLS; k++) begin
      mul_a[k] = col_i[k];
      mul_b[k] = dot_op_i[k];
    end
    if (req_i == mtu_pkg::REQ_SCALE) begin
      mul_a[0] = cell_i;
    end
    for (int k = 0; k < mtu_pkg::GROUP_CELLS; k++) begin
      prod[k]  = mtu_pkg::prod_t'(mul_a[k]) * mtu_pkg::prod_t'(mul_b[k]);
      trunc[k] = prod[k][mtu_pkg::PROD_W-1:mtu_pkg::FRAC_W];
    end
  end

  // Sum the truncated products exactly, then clamp
  always_comb begin
    dot_sum = '0;
    for (int k = 0; k < mtu_pkg::GROUP_CELLS; k++) begin
      dot_sum = dot_sum + mtu_pkg::acc_t'(trunc[k]);
    end
    dot_sat = mtu_pkg::sat_word(dot_sum);
  end

  // Add or subtract the operand element
  always_comb begin
    if (req_i == mtu_pkg::REQ_SUB) begin
      as_sum = mtu_pkg::acc_t'(cell_i) - mtu_pkg::acc_t'(own_i);
    end else begin
      as_sum = mtu_pkg::acc_t'(cell_i) + mtu_pkg::acc_t'(own_i);
    end
  end

  // Select the lane result
  always_comb begin
    case (req_i)
      mtu_pkg::REQ_LOAD:   res_o = own_i;
      mtu_pkg::REQ_READ:   res_o = cell_i;
      mtu_pkg::REQ_MUL:    res_o = dot_sat;
      mtu_pkg::REQ_ADD:    res_o = mtu_pkg::sat_word(as_sum);
      mtu_pkg::REQ_SUB:    res_o = mtu_pkg::sat_word(as_sum);
      mtu_pkg::REQ_SCALE:  res_o = mtu_pkg::sat_word(mtu_pkg::acc_t'(trunc[0]));
      mtu_pkg::REQ_ROTATE: res_o = rot_zero_i ? '0 : dot_sat;
      default:             res_o = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/mtu_store.sv
`default_nettype none
// Matrix cells, staged multiply results and the commit logic
module mtu_store (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mtu_pkg::upd_t    upd_i,
  output mtu_pkg::matrix_t      matrix_o,
  output logic                  ident_nxt_o
);

  mtu_pkg::matrix_t                  matrix_r, matrix_nxt;
  mtu_pkg::matrix_t                  staged_r, staged_nxt;
  logic [mtu_pkg::GROUPS-1:0]        mask_r, mask_nxt;

  // Apply a load, or stage a committed multiply and replace M after the last group
  always_comb begin
    matrix_nxt = matrix_r;
    staged_nxt = staged_r;
    mask_nxt   = mask_r;
    if (upd_i.en) begin
      case (upd_i.req)
        mtu_pkg::REQ_LOAD: begin
          matrix_nxt[upd_i.grp] = upd_i.load_vals;
        end
        mtu_pkg::REQ_MUL: begin
          if (upd_i.commit) begin
            staged_nxt[upd_i.grp] = upd_i.mul_res;
            mask_nxt[upd_i.grp]   = 1'b1;
            if (upd_i.grp == mtu_pkg::LAST_GROUP) begin
              for (int g = 0; g < mtu_pkg::GROUPS - 1; g++) begin
                if (mask_r[g]) begin
                  matrix_nxt[g] = staged_r[g];
                end
              end
              matrix_nxt[mtu_pkg::LAST_GROUP] = upd_i.mul_res;
              mask_nxt = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the matrix and the staging mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r <= mtu_pkg::ident_matrix();
      mask_r   <= '0;
    end else begin
      matrix_r <= matrix_nxt;
      mask_r   <= mask_nxt;
    end
  end

  // Staged cells are only read where the mask says they were written
  always_ff @(posedge clk) begin
    staged_r <= staged_nxt;
  end

  assign matrix_o    = matrix_r;
  assign ident_nxt_o = mtu_pkg::is_identity(matrix_nxt);

endmodule
`default_nettype wire

>>> sv/matrix4_transform_unit_core.sv
`default_nettype none
// 4x4 fixed-point matrix unit (signed Q16.16, matrix reset to identity). Each accepted
// request is registered and worked combinationally by four result lanes (each with four
// 32x32 multipliers and a saturating adder) against the stored matrix; its result is
// captured in the output register when that register is free or being emptied. One
// request per cycle is sustained while the output is not stalled. Matrix updates
// (load, committed multiply of the last group) take effect for the very next request.
module matrix4_transform_unit_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mtu_req_if.sink    in_ch,
  mtu_res_if.source  out_ch
);

  logic             in_vld_r;
  mtu_pkg::item_t   item_r;
  logic             out_vld_r;
  mtu_pkg::group_t  res_r;
  logic             ident_r;

  logic             advance;
  logic             in_take;
  mtu_pkg::matrix_t matrix;
  mtu_pkg::matrix_t cols;
  mtu_pkg::group_t  cells;
  mtu_pkg::group_t  dot_op;
  mtu_pkg::group_t  lane_res;
  mtu_pkg::upd_t    upd;
  logic             ident_nxt;

  // Move a request into the result register when that slot is free or being emptied
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.req    <= mtu_pkg::req_e'(in_ch.req_type);
      item_r.grp    <= in_ch.group;
      item_r.vals   <= {in_ch.val3, in_ch.val2, in_ch.val1, in_ch.val0};
      item_r.commit <= in_ch.commit;
    end
  end

  // Route columns, the addressed group and the dot operand to the lanes
  always_comb begin
    for (int i = 0; i < mtu_pkg::GROUP_CELLS; i++) begin
      for (int k = 0; k < mtu_pkg::GROUPS; k++) begin
        cols[i][k] = matrix[k][i];
      end
    end
    cells  = matrix[item_r.grp];
    dot_op = item_r.vals;
    if (item_r.req == mtu_pkg::REQ_ROTATE) begin
      dot_op[mtu_pkg::GROUP_CELLS-1] = '0;
    end
  end

  for (genvar i = 0; i < mtu_pkg::GROUP_CELLS; i++) begin : g_lane
    mtu_lane u_lane (
      .req_i      (item_r.req),
      .col_i      (cols[i]),
      .dot_op_i   (dot_op),
      .cell_i     (cells[i]),
      .own_i      (item_r.vals[i]),
      .rot_zero_i (i == mtu_pkg::GROUP_CELLS - 1),
      .res_o      (lane_res[i])
    );
  end

  // Update the stored matrix as the request completes
  always_comb begin
    upd.en        = advance;
    upd.req       = item_r.req;
    upd.grp       = item_r.grp;
    upd.commit    = item_r.commit;
    upd.load_vals = item_r.vals;
    upd.mul_res   = lane_res;
  end

  mtu_store u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd_i       (upd),
    .matrix_o    (matrix),
    .ident_nxt_o (ident_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r   <= lane_res;
      ident_r <= ident_nxt;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.res0     = res_r[0];
  assign out_ch.res1     = res_r[1];
  assign out_ch.res2     = res_r[2];
  assign out_ch.res3     = res_r[3];
  assign out_ch.is_ident = ident_r;

endmodule
`default_nettype wire
